@@ sv/glow_line_column_renderer_defines.svh @@
// Assertion helpers for the glow line column renderer.
`ifndef GLOW_LINE_COLUMN_RENDERER_DEFINES_SVH
`define GLOW_LINE_COLUMN_RENDERER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/glr_pkg.sv @@
`timescale 1ns / 1ps

package glr_pkg;

    localparam int WAVE_SLOTS  = 5;
    localparam int HEIGHT_W    = 12;
    localparam int COLOR_W     = 24;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 24;

    // register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_COUNT     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_HEIGHT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_THICKNESS      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE0_COLOR    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE1_COLOR    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE2_COLOR    = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE3_COLOR    = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE4_COLOR    = 4'd7;

    localparam logic [2:0]         RST_WAVE_COUNT = 3'd3;
    localparam logic [6:0]         RST_HEIGHT     = 7'd16;
    localparam logic [2:0]         RST_THICKNESS  = 3'd2;
    localparam logic [COLOR_W-1:0] RST_COLOR0     = 24'hFF0000;
    localparam logic [COLOR_W-1:0] RST_COLOR1     = 24'h00FF00;
    localparam logic [COLOR_W-1:0] RST_COLOR2     = 24'h0000FF;
    localparam logic [COLOR_W-1:0] RST_COLOR3     = 24'hFFFF00;
    localparam logic [COLOR_W-1:0] RST_COLOR4     = 24'h00FFFF;

    // shared multiplier operand widths and reciprocal scale
    localparam int MUL_A_W     = 17;
    localparam int MUL_B_W     = 22;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int RECIP_SHIFT = 26;

    typedef logic signed [HEIGHT_W-1:0] height_t;
    typedef logic [COLOR_W-1:0]         color_t;

    // glow half width in Q.4 units scaled by five: G = 16*(2+3t)
    function automatic logic [8:0] glow_g(input logic [2:0] t);
        logic [8:0] g;
        case (t)
            3'd1:    g = 9'd80;
            3'd2:    g = 9'd128;
            3'd3:    g = 9'd176;
            3'd4:    g = 9'd224;
            3'd5:    g = 9'd272;
            3'd6:    g = 9'd320;
            default: g = 9'd80;
        endcase
        return g;
    endfunction

    // (2+3t)^2: weight = floor(diff^2 / m2)
    function automatic logic [8:0] glow_m2(input logic [2:0] t);
        logic [8:0] m;
        case (t)
            3'd1:    m = 9'd25;
            3'd2:    m = 9'd64;
            3'd3:    m = 9'd121;
            3'd4:    m = 9'd196;
            3'd5:    m = 9'd289;
            3'd6:    m = 9'd400;
            default: m = 9'd25;
        endcase
        return m;
    endfunction

    // floor(2^26 / m2)
    function automatic logic [MUL_B_W-1:0] glow_recip(input logic [2:0] t);
        logic [MUL_B_W-1:0] r;
        case (t)
            3'd1:    r = 22'd2684354;
            3'd2:    r = 22'd1048576;
            3'd3:    r = 22'd554618;
            3'd4:    r = 22'd342392;
            3'd5:    r = 22'd232210;
            3'd6:    r = 22'd167772;
            default: r = 22'd2684354;
        endcase
        return r;
    endfunction

endpackage

@@ sv/glow_line_column_renderer.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-----------------------------------------
// in       | input     | in_valid/in_ready   | here_height_0..4, next_height_0..4
// out      | output    | out_valid/out_ready | pixel_row, red, green, blue, last_row
// cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One column transfer yields display_height pixel transfers, rows ascending; the height
// is clamped to 1..MAX_ROWS. Per row, each active wave gets a distance step; a wave
// inside the glow then goes through square, reciprocal multiply, back multiply, correct,
// R, G and B steps, the multiplies sharing one multiplier; an emit step ends the row.
// rst_n is asynchronous active low; config returns to its documented reset values.
// The sequencer holds in its emit step while the output register is full and unread.
`include "glow_line_column_renderer_defines.svh"

module glow_line_column_renderer #(
    parameter int MAX_WAVE_COUNT = 5,
    parameter int MAX_ROWS       = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [glr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [glr_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [glr_pkg::HEIGHT_W-1:0] here_height_0,
    input  logic signed [glr_pkg::HEIGHT_W-1:0] here_height_1,
    input  logic signed [glr_pkg::HEIGHT_W-1:0] here_height_2,
    input  logic signed [glr_pkg::HEIGHT_W-1:0] here_height_3,
    input  logic signed [glr_pkg::HEIGHT_W-1:0] here_height_4,
    input  logic signed [glr_pkg::HEIGHT_W-1:0] next_height_0,
    input  logic signed [glr_pkg::HEIGHT_W-1:0] next_height_1,
    input  logic signed [glr_pkg::HEIGHT_W-1:0] next_height_2,
    input  logic signed [glr_pkg::HEIGHT_W-1:0] next_height_3,
    input  logic signed [glr_pkg::HEIGHT_W-1:0] next_height_4,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [5:0]                        pixel_row,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    output logic                              last_row
);

    // wave slots actually usable
    localparam int WAVE_LIMIT = (MAX_WAVE_COUNT < glr_pkg::WAVE_SLOTS) ?
                                MAX_WAVE_COUNT : glr_pkg::WAVE_SLOTS;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    // sum of all contributions before saturation
    localparam int ACC_W  = $clog2(MAX_WAVE_COUNT * 255 + 1);
    localparam int MA     = glr_pkg::MUL_A_W;
    localparam int MB     = glr_pkg::MUL_B_W;
    localparam int MP     = glr_pkg::MUL_P_W;
    localparam int RS     = glr_pkg::RECIP_SHIFT;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIST = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_REC  = 4'd3;
    localparam logic [3:0] S_FIX  = 4'd4;
    localparam logic [3:0] S_WT   = 4'd5;
    localparam logic [3:0] S_RED  = 4'd6;
    localparam logic [3:0] S_GRN  = 4'd7;
    localparam logic [3:0] S_BLU  = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    // ---------------- configuration registers ----------------
    logic [2:0]         wave_count_reg;
    logic [6:0]         height_cfg_reg;
    logic [2:0]         thickness_reg;
    glr_pkg::color_t    color_reg [glr_pkg::WAVE_SLOTS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_count_reg <= glr_pkg::RST_WAVE_COUNT;
            height_cfg_reg <= glr_pkg::RST_HEIGHT;
            thickness_reg  <= glr_pkg::RST_THICKNESS;
            color_reg[0]   <= glr_pkg::RST_COLOR0;
            color_reg[1]   <= glr_pkg::RST_COLOR1;
            color_reg[2]   <= glr_pkg::RST_COLOR2;
            color_reg[3]   <= glr_pkg::RST_COLOR3;
            color_reg[4]   <= glr_pkg::RST_COLOR4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                glr_pkg::REG_WAVE_COUNT:     wave_count_reg <= cfg_data[2:0];
                glr_pkg::REG_DISPLAY_HEIGHT: height_cfg_reg <= cfg_data[6:0];
                glr_pkg::REG_THICKNESS:      thickness_reg  <= cfg_data[2:0];
                glr_pkg::REG_WAVE0_COLOR:    color_reg[0]   <= cfg_data[23:0];
                glr_pkg::REG_WAVE1_COLOR:    color_reg[1]   <= cfg_data[23:0];
                glr_pkg::REG_WAVE2_COLOR:    color_reg[2]   <= cfg_data[23:0];
                glr_pkg::REG_WAVE3_COLOR:    color_reg[3]   <= cfg_data[23:0];
                glr_pkg::REG_WAVE4_COLOR:    color_reg[4]   <= cfg_data[23:0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // ---------------- clamped settings ----------------
    logic [2:0]        count_eff;
    logic [ROWS_W-1:0] rows_eff;
    logic [2:0]        thick_eff;
    logic [8:0]        glow_g;
    logic [8:0]        glow_m2;
    logic [MB-1:0]     glow_recip;

    always_comb
    begin
        if (wave_count_reg == 3'd0)
            count_eff = 3'd1;
        else if (32'(wave_count_reg) > WAVE_LIMIT)
            count_eff = 3'(WAVE_LIMIT);
        else
            count_eff = wave_count_reg;

        if (height_cfg_reg == 7'd0)
            rows_eff = ROWS_W'(1);
        else if (32'(height_cfg_reg) > MAX_ROWS)
            rows_eff = ROWS_W'(MAX_ROWS);
        else
            rows_eff = ROWS_W'(height_cfg_reg);

        if (thickness_reg == 3'd0)
            thick_eff = 3'd1;
        else if (thickness_reg > 3'd6)
            thick_eff = 3'd6;
        else
            thick_eff = thickness_reg;
    end

    assign glow_g     = glr_pkg::glow_g(thick_eff);
    assign glow_m2    = glr_pkg::glow_m2(thick_eff);
    assign glow_recip = glr_pkg::glow_recip(thick_eff);

    // ---------------- input capture: span per wave ----------------
    glr_pkg::height_t here_h [glr_pkg::WAVE_SLOTS];
    glr_pkg::height_t next_h [glr_pkg::WAVE_SLOTS];
    glr_pkg::height_t lo_reg [glr_pkg::WAVE_SLOTS];
    glr_pkg::height_t hi_reg [glr_pkg::WAVE_SLOTS];

    assign here_h[0] = here_height_0;
    assign here_h[1] = here_height_1;
    assign here_h[2] = here_height_2;
    assign here_h[3] = here_height_3;
    assign here_h[4] = here_height_4;
    assign next_h[0] = next_height_0;
    assign next_h[1] = next_height_1;
    assign next_h[2] = next_height_2;
    assign next_h[3] = next_height_3;
    assign next_h[4] = next_height_4;

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < glr_pkg::WAVE_SLOTS; k++)
            begin
                lo_reg[k] <= (here_h[k] < next_h[k]) ? here_h[k] : next_h[k];
                hi_reg[k] <= (here_h[k] < next_h[k]) ? next_h[k] : here_h[k];
            end
        end
    end

    // ---------------- sequencer and datapath registers ----------------
    logic [3:0]       state_reg,  state_next;
    logic [ROW_W-1:0] row_reg,    row_next;
    logic [2:0]       wave_reg,   wave_next;
    logic [8:0]       diff_reg,   diff_next;    // G - 5*d16
    logic [16:0]      sq_reg,     sq_next;      // diff^2
    logic [8:0]       q_reg,      q_next;       // reciprocal quotient estimate
    logic [16:0]      back_reg,   back_next;    // q * m2
    logic [8:0]       w_reg,      w_next;       // weight, 256 = 1.0
    logic [ACC_W-1:0] acc_r_reg,  acc_r_next;
    logic [ACC_W-1:0] acc_g_reg,  acc_g_next;
    logic [ACC_W-1:0] acc_b_reg,  acc_b_next;

    logic             out_valid_reg;
    logic [5:0]       pixel_row_reg;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;
    logic [7:0]       blue_reg;
    logic             last_row_reg;

    // distance from row to the wave's span, Q.4
    logic [8:0]               row_wide;
    logic signed [14:0]       fy;
    logic signed [14:0]       lo_x;
    logic signed [14:0]       hi_x;
    logic [14:0]              d16;
    logic [17:0]              dd;
    logic                     in_glow;

    assign row_wide = 9'(row_reg);
    assign fy       = $signed({2'b00, row_wide, 4'b0000});
    assign lo_x     = {{3{lo_reg[wave_reg][glr_pkg::HEIGHT_W-1]}}, lo_reg[wave_reg]};
    assign hi_x     = {{3{hi_reg[wave_reg][glr_pkg::HEIGHT_W-1]}}, hi_reg[wave_reg]};

    always_comb
    begin
        if (fy < lo_x)
            d16 = 15'(lo_x - fy);
        else if (fy > hi_x)
            d16 = 15'(fy - hi_x);
        else
            d16 = '0;
    end

    assign dd      = {1'b0, d16, 2'b00} + {3'b000, d16};
    assign in_glow = dd < {9'd0, glow_g};

    // shared multiplier
    logic [MA-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic [MP-1:0] mul_p;
    logic [7:0]    chan;

    always_comb
    begin
        case (state_reg)
            S_RED:   chan = color_reg[wave_reg][23:16];
            S_GRN:   chan = color_reg[wave_reg][15:8];
            default: chan = color_reg[wave_reg][7:0];
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_SQ:
            begin
                mul_a = MA'(diff_reg);
                mul_b = MB'(diff_reg);
            end
            S_REC:
            begin
                mul_a = sq_reg;
                mul_b = glow_recip;
            end
            S_FIX:
            begin
                mul_a = MA'(q_reg);
                mul_b = MB'(glow_m2);
            end
            default:
            begin
                mul_a = MA'(w_reg);
                mul_b = MB'(chan);
            end
        endcase
    end

    assign mul_p = MP'(mul_a) * MP'(mul_b);

    // remainder check after the back multiply; estimate is exact or one low
    logic [16:0] rem;
    assign rem = sq_reg - back_reg;

    // pixel contribution from the channel multiply
    logic [7:0] contrib;
    assign contrib = mul_p[15:8];

    logic [ROWS_W-1:0] row_ext;
    logic              row_last;
    logic [3:0]        wave_inc;
    logic              wave_last;
    logic              emit_go;

    assign row_ext   = ROWS_W'(row_reg);
    assign row_last  = (row_ext + ROWS_W'(1)) == rows_eff;
    assign wave_inc  = {1'b0, wave_reg} + 4'd1;
    assign wave_last = wave_inc >= {1'b0, count_eff};
    assign emit_go   = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        wave_next  = wave_reg;
        diff_next  = diff_reg;
        sq_next    = sq_reg;
        q_next     = q_reg;
        back_next  = back_reg;
        w_next     = w_reg;
        acc_r_next = acc_r_reg;
        acc_g_next = acc_g_reg;
        acc_b_next = acc_b_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_DIST;
                    row_next   = '0;
                    wave_next  = '0;
                    acc_r_next = '0;
                    acc_g_next = '0;
                    acc_b_next = '0;
                end
            end
            S_DIST:
            begin
                diff_next = glow_g - dd[8:0];
                if (in_glow)
                    state_next = S_SQ;
                else if (wave_last)
                    state_next = S_EMIT;
                else
                    wave_next = wave_inc[2:0];
            end
            S_SQ:
            begin
                sq_next    = mul_p[16:0];
                state_next = S_REC;
            end
            S_REC:
            begin
                q_next     = mul_p[RS+8:RS];
                state_next = S_FIX;
            end
            S_FIX:
            begin
                back_next  = mul_p[16:0];
                state_next = S_WT;
            end
            S_WT:
            begin
                w_next     = (rem >= {8'd0, glow_m2}) ? q_reg + 9'd1 : q_reg;
                state_next = S_RED;
            end
            S_RED:
            begin
                acc_r_next = acc_r_reg + ACC_W'(contrib);
                state_next = S_GRN;
            end
            S_GRN:
            begin
                acc_g_next = acc_g_reg + ACC_W'(contrib);
                state_next = S_BLU;
            end
            S_BLU:
            begin
                acc_b_next = acc_b_reg + ACC_W'(contrib);
                if (wave_last)
                    state_next = S_EMIT;
                else
                begin
                    wave_next  = wave_inc[2:0];
                    state_next = S_DIST;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    wave_next  = '0;
                    acc_r_next = '0;
                    acc_g_next = '0;
                    acc_b_next = '0;
                    if (row_last)
                        state_next = S_IDLE;
                    else
                    begin
                        row_next   = row_reg + ROW_W'(1);
                        state_next = S_DIST;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            wave_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            wave_reg  <= wave_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg  <= diff_next;
        sq_reg    <= sq_next;
        q_reg     <= q_next;
        back_reg  <= back_next;
        w_reg     <= w_next;
        acc_r_reg <= acc_r_next;
        acc_g_reg <= acc_g_next;
        acc_b_reg <= acc_b_next;
    end

    // ---------------- output register ----------------
    function automatic logic [7:0] sat8(input logic [ACC_W-1:0] v);
        logic [7:0] s;
        if (32'(v) > 255)
            s = 8'hFF;
        else
            s = 8'(v);
        return s;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_go)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            pixel_row_reg <= row_wide[5:0];
            red_reg       <= sat8(acc_r_reg);
            green_reg     <= sat8(acc_g_reg);
            blue_reg      <= sat8(acc_b_reg);
            last_row_reg  <= row_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_row = pixel_row_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign last_row  = last_row_reg;

    // ---------------- assertions ----------------
    `GLR_ASSERT_NOW(a_wave_in_range, (state_reg != S_IDLE), (wave_reg < count_eff), "wave index beyond active count")
    `GLR_ASSERT_NOW(a_recip_close, (state_reg == S_WT), (rem < {glow_m2, 1'b0}), "reciprocal estimate off by more than one")
    `GLR_ASSERT_NOW(a_weight_max, (state_reg == S_RED), (w_reg <= 9'd256), "weight above one")
    `GLR_ASSERT_NEXT(a_column_done, (emit_go && row_last), (state_reg == S_IDLE && out_valid_reg && last_row_reg), "column end not closed")

endmodule
